// File: sv/tns_pkg.sv
// Package for the turbulence noise sampler: request, response and job types,
// register indexes and fixed constants. No dependencies.
`default_nettype none
package tns_pkg;

   localparam logic [0:0] CSR_START_SIZE   = 1'b0;
   localparam logic [0:0] CSR_OCTAVE_SHIFT = 1'b1;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [4:0] START_SIZE_RESET   = 5'd13;
   localparam logic [4:0] OCTAVE_SHIFT_RESET = 5'd8;
   localparam logic [4:0] MAX_SIZE_LOG2      = 5'd20;

   localparam int ACC_W  = 57;
   localparam int PROD_W = 55;
   localparam int WGT_W  = 42;
   localparam int FRAC_W = 21;
   localparam int SCALE_SHIFT = 11;

   typedef struct packed {
      logic        action;
      logic [15:0] coord_x;
      logic [15:0] coord_y;
      logic [14:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [26:0] turbulence_value;
      logic [7:0]  pixel_byte;
   } rsp_type;

   typedef struct packed {
      logic        is_load;
      logic [4:0]  s0;
      logic [4:0]  step;
      logic [15:0] x;
      logic [15:0] y;
      logic [14:0] value;
   } job_type;

   typedef struct packed {
      logic busy;
      logic sampling;
   } back_stat_type;

endpackage
`default_nettype wire

// File: sv/tns_front.sv
// Front end: holds the configuration registers and turns each request into a job.
// Depends on tns_pkg.
`default_nettype none
module tns_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_en,
   input  wire logic [0:0]        csr_index,
   input  wire logic [4:0]        csr_wdata,
   input  wire tns_pkg::req_type  req_data,
   output tns_pkg::job_type       job
);
   logic [4:0] start_ff, start_in;
   logic [4:0] shift_ff, shift_in;

   always_comb begin
      start_in = start_ff;
      shift_in = shift_ff;
      if (csr_write_en) begin
         case (csr_index)
            tns_pkg::CSR_START_SIZE:   start_in = csr_wdata;
            tns_pkg::CSR_OCTAVE_SHIFT: shift_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= tns_pkg::START_SIZE_RESET;
         shift_ff <= tns_pkg::OCTAVE_SHIFT_RESET;
      end else begin
         start_ff <= start_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      job.is_load = (req_data.action == tns_pkg::ACTION_LOAD);
      job.s0      = (start_ff > tns_pkg::MAX_SIZE_LOG2) ? tns_pkg::MAX_SIZE_LOG2 : start_ff;
      job.step    = (shift_ff == 5'd0) ? 5'd1 : shift_ff;
      job.x       = req_data.coord_x;
      job.y       = req_data.coord_y;
      job.value   = req_data.entry_value;
   end
endmodule
`default_nettype wire

// File: sv/tns_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on tns_pkg.
`default_nettype none
module tns_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tns_pkg::job_type  push_job,
   output logic                   full,
   output logic                   nonempty,
   input  wire logic              pop,
   output tns_pkg::job_type       head
);
   tns_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign nonempty = (count_ff != 2'd0);
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule
`default_nettype wire

// File: sv/tns_back.sv
// Back end: noise table memory, wrap arithmetic, octave sequencer with a
// multiply-accumulate pipeline and the response register. Depends on tns_pkg.
`default_nettype none
module tns_back #(
   parameter int TABLE_WIDTH  = 256,
   parameter int TABLE_HEIGHT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire tns_pkg::job_type  job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tns_pkg::rsp_type       rsp_data,
   output tns_pkg::back_stat_type stat
);
   localparam int CW = $clog2(TABLE_WIDTH);
   localparam int RW = $clog2(TABLE_HEIGHT);
   localparam int AW = $clog2(TABLE_WIDTH * TABLE_HEIGHT);
   localparam int DEPTH = TABLE_WIDTH * TABLE_HEIGHT;
   localparam longint unsigned RecipX = ((64'd1 << 32) + TABLE_WIDTH - 1) / TABLE_WIDTH;
   localparam longint unsigned RecipY = ((64'd1 << 32) + TABLE_HEIGHT - 1) / TABLE_HEIGHT;
   localparam logic [31:0] MX_C = 32'(RecipX);
   localparam logic [31:0] MY_C = 32'(RecipY);
   localparam int ACC_W  = tns_pkg::ACC_W;
   localparam int PROD_W = tns_pkg::PROD_W;
   localparam int WGT_W  = tns_pkg::WGT_W;
   localparam int FRAC_W = tns_pkg::FRAC_W;
   localparam int SC_W   = tns_pkg::SCALE_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_REM, ST_ROW, ST_CORNER, ST_WRITE, ST_DRAIN, ST_FINAL
   } state_type;

   state_type        state_ff, state_in;
   tns_pkg::job_type job_ff, job_in;
   logic [4:0]       cur_s_ff, cur_s_in;
   logic [15:0]      qx_ff, qx_in, qy_ff, qy_in;
   logic [CW-1:0]    cx_ff, cx_in;
   logic [RW-1:0]    cy_ff, cy_in;
   logic [AW-1:0]    rowc_ff, rowc_in, rowp_ff, rowp_in;
   logic [1:0]       corner_ff, corner_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [WGT_W-1:0] w_ff, w_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic             d1_vld_ff, d1_vld_in, d2_vld_ff, d2_vld_in;
   logic [4:0]       d1_sh_ff, d1_sh_in, d2_sh_ff, d2_sh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tns_pkg::rsp_type rsp_ff, rsp_in;

   logic [14:0]      mem [DEPTH];
   logic [14:0]      rd_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;

   logic [15:0]      xs, ys;
   logic [47:0]      mulx, muly;
   logic [31:0]      qwx, qwy;
   logic [15:0]      remx, remy;
   logic [CW-1:0]    px;
   logic [RW-1:0]    py;
   logic [31:0]      rowc_full, rowp_full;
   logic [FRAC_W-1:0] one, fmask, fx, fy, wx, wy;
   logic [CW-1:0]    col_sel;
   logic [AW-1:0]    row_sel;
   logic [ACC_W+1:0] pfull;
   logic [ACC_W-1:0] addend;
   logic [ACC_W+SC_W-1:0] scaled;
   logic             out_free;

   always_comb begin
      xs   = job_ff.x >> cur_s_ff;
      ys   = job_ff.y >> cur_s_ff;
      mulx = 48'(xs) * 48'(MX_C);
      muly = 48'(ys) * 48'(MY_C);
      qx_in = mulx[47:32];
      qy_in = muly[47:32];
      qwx  = 32'(qx_ff) * 32'(TABLE_WIDTH);
      qwy  = 32'(qy_ff) * 32'(TABLE_HEIGHT);
      remx = xs - qwx[15:0];
      remy = ys - qwy[15:0];
      cx_in = remx[CW-1:0];
      cy_in = remy[RW-1:0];
      px = (cx_ff == '0) ? CW'(TABLE_WIDTH - 1) : cx_ff - CW'(1);
      py = (cy_ff == '0) ? RW'(TABLE_HEIGHT - 1) : cy_ff - RW'(1);
      rowc_full = 32'(cy_ff) * 32'(TABLE_WIDTH);
      rowp_full = 32'(py) * 32'(TABLE_WIDTH);
      rowc_in = rowc_full[AW-1:0];
      rowp_in = rowp_full[AW-1:0];

      one   = FRAC_W'(1) << cur_s_ff;
      fmask = one - FRAC_W'(1);
      fx    = FRAC_W'(job_ff.x) & fmask;
      fy    = FRAC_W'(job_ff.y) & fmask;
      col_sel = corner_ff[0] ? px : cx_ff;
      wx      = corner_ff[0] ? one - fx : fx;
      row_sel = corner_ff[1] ? rowp_ff : rowc_ff;
      wy      = corner_ff[1] ? one - fy : fy;
      mem_raddr = row_sel + AW'(col_sel);
      w_in      = WGT_W'(wx) * WGT_W'(wy);

      pfull   = (ACC_W+2)'(w_ff) * (ACC_W+2)'(rd_ff);
      prod_in = pfull[PROD_W-1:0];
      addend  = ACC_W'(prod_ff) << d2_sh_ff;
      scaled  = {acc_ff, {SC_W{1'b0}}} >> {job_ff.s0, 1'b0};

      mem_we    = (state_ff == ST_WRITE);
      mem_waddr = rowc_ff + AW'(cx_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cur_s_in     = cur_s_ff;
      corner_in    = corner_ff;
      acc_in       = d2_vld_ff ? acc_ff + addend : acc_ff;
      d1_vld_in    = (state_ff == ST_CORNER);
      d1_sh_in     = job_ff.s0 - cur_s_ff;
      d2_vld_in    = d1_vld_ff;
      d2_sh_in     = d1_sh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               cur_s_in = job.is_load ? 5'd0 : job.s0;
               acc_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: state_in = ST_REM;
         ST_REM: state_in = ST_ROW;
         ST_ROW: begin
            corner_in = 2'd0;
            state_in  = job_ff.is_load ? ST_WRITE : ST_CORNER;
         end
         ST_CORNER: begin
            corner_in = corner_ff + 2'd1;
            if (corner_ff == 2'd3) begin
               if (cur_s_ff >= job_ff.step) begin
                  cur_s_in = cur_s_ff - job_ff.step;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_DRAIN: begin
            if (!d1_vld_ff && !d2_vld_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.turbulence_value = scaled[26:0];
               rsp_in.pixel_byte       = scaled[15:8];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         d1_vld_ff    <= 1'b0;
         d2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         d1_vld_ff    <= d1_vld_in;
         d2_vld_ff    <= d2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff    <= job_in;
      cur_s_ff  <= cur_s_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      rowc_ff   <= rowc_in;
      rowp_ff   <= rowp_in;
      corner_ff <= corner_in;
      acc_ff    <= acc_in;
      w_ff      <= w_in;
      prod_ff   <= prod_in;
      d1_sh_ff  <= d1_sh_in;
      d2_sh_ff  <= d2_sh_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= job_ff.value;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.busy     = (state_ff != ST_IDLE);
   assign stat.sampling = (state_ff != ST_IDLE) && !job_ff.is_load;
endmodule
`default_nettype wire

// File: sv/turbulence_noise_sampler_unit.sv
// Top level of the turbulence noise sampler: front end, job queue and back end.
// Depends on tns_pkg, tns_front, tns_queue and tns_back.
//
//   Channel   Ports                                   Direction
//   request   req_valid, req_stall, req_data          in
//   response  rsp_valid, rsp_stall, rsp_data          out
//   csr       csr_write_en, csr_index, csr_wdata      in
//
// A load request is taken in the idle state and then passes through DIV, REM,
// ROW and WRITE. A sample request passes, per octave, through DIV, REM, ROW and
// one CORNER state per corner, read in turn through the single read port of the
// noise table, then drains the pipeline and registers the response in FINAL.
// Reset is synchronous and clears control state; the table is not cleared.
// The two-entry queue lets requests arrive while the back end works or while
// a response waits under stall.
`default_nettype none
module turbulence_noise_sampler_unit #(
   parameter int TABLE_WIDTH  = 256,
   parameter int TABLE_HEIGHT = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tns_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tns_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [0:0]       csr_index,
   input  wire logic [4:0]       csr_wdata
);
   tns_pkg::job_type       new_job, head_job;
   tns_pkg::back_stat_type back_stat;
   logic q_full, q_nonempty, q_pop, q_push;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   tns_front u_front (
      .clock, .reset, .csr_write_en, .csr_index, .csr_wdata, .req_data,
      .job(new_job)
   );

   tns_queue u_queue (
      .clock, .reset, .push(q_push), .push_job(new_job), .full(q_full),
      .nonempty(q_nonempty), .pop(q_pop), .head(head_job)
   );

   tns_back #(
      .TABLE_WIDTH(TABLE_WIDTH), .TABLE_HEIGHT(TABLE_HEIGHT)
   ) u_back (
      .clock, .reset, .job_valid(q_nonempty), .job(head_job), .job_pop(q_pop),
      .rsp_valid, .rsp_stall, .rsp_data, .stat(back_stat)
   );

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty && !back_stat.busy) else $error("pop from empty queue");
   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_stat.sampling)) else $error("response without sample");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall) else $error("activity after reset");
`endif
endmodule
`default_nettype wire
